[rtl/core/bdq_pkg.sv]
// Shared types and operation/status codes for the bounded deque.
package bdq_pkg;

    typedef logic signed [31:0] t_word;
    typedef logic [2:0]         t_func;
    typedef logic [1:0]         t_status;

    localparam t_func FUNC_PUSH_FRONT = 3'd0;
    localparam t_func FUNC_PUSH_BACK  = 3'd1;
    localparam t_func FUNC_POP_FRONT  = 3'd2;
    localparam t_func FUNC_POP_BACK   = 3'd3;
    localparam t_func FUNC_SEARCH     = 3'd4;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    localparam int POS_W = 4;
    localparam int OCC_W = 5;

endpackage

[rtl/core/bounded_deque_with_search.sv]
// Top level: bounded deque with linear search over a ring buffer.
//
// Input channel (i_valid / o_stall) carries one word: i_func and i_value.
// Output channel (o_valid / i_stall) carries one result word per input:
// o_status, o_position and o_occupancy after the operation.
// A word moves on a rising edge where valid is high and stall is low.
// Push front/back, pop front/back, unused codes and a search of an empty deque
// finish in the cycle they are accepted; the result appears in the output
// register on the next cycle. A search reads the entries from the front, one
// per cycle through the registered read port of the store, comparing the
// previous read while the next is issued; it ends at the first match or
// after the last entry is compared.
// Push and pop words are accepted one per cycle while no result is held
// under stall.
// The input side is stalled during a search and while an unread result is
// held under stall. Reset empties the deque; store contents are not cleared.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [2:0]     i_func,
    input  logic signed [31:0] i_value,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_status,
    output logic [POS_W-1:0] o_position,
    output logic [OCC_W-1:0] o_occupancy
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(CAPACITY);
    localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state          r_state,     n_state;
    logic [AW-1:0]   r_front,     n_front;
    logic [FW-1:0]   r_fill,      n_fill;
    t_word           r_key,       n_key;
    logic [AW-1:0]   r_rd_addr,   n_rd_addr;
    logic [FW-1:0]   r_iss,       n_iss;
    logic            r_chk_valid, n_chk_valid;
    logic [AW-1:0]   r_chk_k,     n_chk_k;
    logic            r_out_valid, n_out_valid;
    t_status         r_status,    n_status;
    logic [POS_W-1:0] r_position, n_position;
    logic [OCC_W-1:0] r_occ,      n_occ;

    logic            accept;
    logic            we;
    logic [AW-1:0]   waddr;
    t_word           rdata;
    logic [SW-1:0]   back_sum;
    logic [AW-1:0]   back_idx;
    logic [AW-1:0]   front_dec;
    logic [AW-1:0]   front_inc;
    logic [AW-1:0]   rd_inc;
    logic            full;
    logic            empty;

    bdq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (r_rd_addr),
        .o_rdata (rdata)
    );

    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    assign full      = (r_fill >= FULL_CNT);
    assign empty     = (r_fill == '0);
    assign back_sum  = SW'(r_front) + SW'(r_fill);
    assign back_idx  = (back_sum >= CAP_S) ? AW'(back_sum - CAP_S) : back_sum[AW-1:0];
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign rd_inc    = (r_rd_addr == LAST_IDX) ? '0 : r_rd_addr + AW'(1);

    always_comb begin
        logic [31:0] fill_ext;
        logic [31:0] k_ext;
        n_state     = r_state;
        n_front     = r_front;
        n_fill      = r_fill;
        n_key       = r_key;
        n_rd_addr   = r_rd_addr;
        n_iss       = r_iss;
        n_chk_valid = 1'b0;
        n_chk_k     = r_chk_k;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_position  = r_position;
        n_occ       = r_occ;
        we          = 1'b0;
        waddr       = back_idx;
        fill_ext    = 32'(r_fill);
        k_ext       = 32'(r_chk_k);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status   = ST_DONE;
                    n_position = '0;
                    n_out_valid = 1'b1;
                    case (i_func)
                        FUNC_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = front_dec;
                                n_front = front_dec;
                                n_fill  = r_fill + FW'(1);
                            end
                        end
                        FUNC_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                we     = 1'b1;
                                waddr  = back_idx;
                                n_fill = r_fill + FW'(1);
                            end
                        end
                        FUNC_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front = front_inc;
                                n_fill  = r_fill - FW'(1);
                            end
                        end
                        FUNC_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_fill = r_fill - FW'(1);
                            end
                        end
                        FUNC_SEARCH: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_SCAN;
                                n_key       = i_value;
                                n_rd_addr   = r_front;
                                n_iss       = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    fill_ext = 32'(n_fill);
                    n_occ    = fill_ext[OCC_W-1:0];
                end
            end
            S_SCAN: begin
                // issue the next read while the previous one is compared
                if (r_iss < r_fill) begin
                    n_chk_valid = 1'b1;
                    n_chk_k     = r_iss[AW-1:0];
                    n_iss       = r_iss + FW'(1);
                    n_rd_addr   = rd_inc;
                end
                if (r_chk_valid && (rdata == r_key)) begin
                    n_state     = S_IDLE;
                    n_chk_valid = 1'b0;
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_position  = k_ext[POS_W-1:0];
                    n_occ       = fill_ext[OCC_W-1:0];
                end else if (r_chk_valid && (r_iss == r_fill)) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_NOT_FOUND;
                    n_position  = '0;
                    n_occ       = fill_ext[OCC_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_fill      <= '0;
            r_iss       <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_fill      <= n_fill;
            r_iss       <= n_iss;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
        r_key      <= n_key;
        r_rd_addr  <= n_rd_addr;
        r_chk_k    <= n_chk_k;
        r_status   <= n_status;
        r_position <= n_position;
        r_occ      <= n_occ;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_occupancy = r_occ;

endmodule

[rtl/core/bdq_store.sv]
// Entry storage: one write port, one registered read port.
module bdq_store
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_word         o_rdata
);

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
